// ===== rtl/bkw_pkg.sv =====
package bkw_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // port widths of the item fields
  localparam int POS_W    = 18;
  localparam int RATIO_W  = 17;
  localparam int WEIGHT_W = 32;
  localparam int KSEL_W   = 3;

  // datapath widths are FRAC_BITS plus these integer-part allowances
  localparam int IW_X  = 4;   // u, q, 1+u, 1+q, q-u
  localparam int NW_X  = 13;  // normalizer quotient
  localparam int PSW_X = 24;  // P*S product

  localparam int NUM_KER  = 6;
  localparam int POW_MAX  = 10;  // highest power of (1+q)
  localparam int POLY_LAT = 10;  // register stages in the polynomial pipe

  typedef logic [KSEL_W-1:0] ksel_t;
  localparam ksel_t KER_LAST = 3'd5;

  typedef enum logic [1:0] {SHAPE_ONE, SHAPE_LIN, SHAPE_CUBIC} shape_e;

  typedef logic signed [9:0] coef_t;

  // coefficient of u^j as a polynomial in q, index i = power of q
  localparam coef_t KCOEF [NUM_KER][4][7] = '{
    '{'{2, -2, 2, 0, 0, 0, 0}, '{3, -3, 0, 0, 0, 0, 0},
      '{default: 0}, '{default: 0}},
    '{'{1, -2, 3, 0, 0, 0, 0}, '{2, -4, 0, 0, 0, 0, 0},
      '{default: 0}, '{default: 0}},
    '{'{1, -2, 2, 0, 0, 0, 0}, '{2, -3, 0, 0, 0, 0, 0},
      '{default: 0}, '{default: 0}},
    '{'{3, -16, 39, -30, 10, 0, 0}, '{14, -63, 84, -35, 0, 0, 0},
      '{14, -56, 28, 0, 0, 0, 0}, '{default: 0}},
    '{'{1, -10, 45, -84, 77, -30, 5}, '{8, -70, 216, -280, 152, -30, 0},
      '{18, -144, 300, -240, 54, 0, 0}, '{12, -90, 120, -30, 0, 0, 0}},
    '{'{3, -24, 50, -40, 9, 0, 0}, '{30, -127, 160, -61, 0, 0, 0},
      '{77, -182, 119, 0, 0, 0, 0}, '{56, -70, 0, 0, 0, 0, 0}}
  };

  localparam logic [12:0] KNUM [NUM_KER] = '{2, 6, 60, 60, 420, 5040};
  localparam logic [3:0]  KPOW [NUM_KER] = '{3, 4, 6, 8, 10, 10};
  localparam shape_e KSHAPE [NUM_KER] = '{SHAPE_ONE, SHAPE_LIN, SHAPE_CUBIC,
                                          SHAPE_CUBIC, SHAPE_CUBIC, SHAPE_CUBIC};

  // selector codes without a kernel read table row zero, result is forced later
  function automatic ksel_t kidx(ksel_t k);
    return (k > KER_LAST) ? '0 : k;
  endfunction

endpackage

// ===== rtl/bkw_rmul.sv =====
module bkw_rmul #(
  parameter int AW        = 16,
  parameter int BW        = 16,
  parameter int RW        = 16,
  parameter int FRAC_BITS = bkw_pkg::FRAC_BITS_DEF
) (
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [RW-1:0] p_o
);

  localparam int PW = AW + BW;

  logic [AW-1:0]           mag_a;
  logic [BW-1:0]           mag_b;
  logic [PW-1:0]           prod;
  logic [PW-FRAC_BITS-1:0] rnd;
  logic                    neg;

  // sign-magnitude product, rounded half away from zero
  assign neg   = a_i[AW-1] ^ b_i[BW-1];
  assign mag_a = a_i[AW-1] ? AW'(~a_i + 1'b1) : AW'(a_i);
  assign mag_b = b_i[BW-1] ? BW'(~b_i + 1'b1) : BW'(b_i);
  assign prod  = PW'(mag_a) * PW'(mag_b);
  assign rnd   = (PW-FRAC_BITS)'((prod + PW'(2**(FRAC_BITS-1))) >> FRAC_BITS);
  assign p_o   = neg ? -RW'(rnd) : RW'(rnd);

endmodule

// ===== rtl/bkw_poly.sv =====
module bkw_poly #(
  parameter int FRAC_BITS = bkw_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              en_i,
  input  logic signed [FRAC_BITS+bkw_pkg::IW_X-1:0]         u_i,
  input  logic signed [FRAC_BITS+bkw_pkg::IW_X-1:0]         q_i,
  input  bkw_pkg::ksel_t                                    k_i,
  output logic signed [FRAC_BITS+bkw_pkg::PSW_X-1:0]        ps_o
);
  import bkw_pkg::*;

  localparam int IW  = FRAC_BITS + IW_X;
  localparam int CW  = FRAC_BITS + 14;
  localparam int PW  = FRAC_BITS + 18;
  localparam int SW  = FRAC_BITS + 8;
  localparam int PSW = FRAC_BITS + PSW_X;
  localparam int NCS = 6;  // q-horner stages

  localparam logic signed [IW-1:0] I_ONE = IW'(2**FRAC_BITS);
  localparam logic signed [SW-1:0] S_ONE = SW'(2**FRAC_BITS);

  function automatic logic signed [CW-1:0] cval(ksel_t k, int j, int i);
    return CW'(KCOEF[kidx(k)][j[1:0]][i[2:0]]) <<< FRAC_BITS;
  endfunction

  logic signed [IW-1:0] cu_q [NCS];
  logic signed [IW-1:0] cq_q [NCS];
  ksel_t                ck_q [NCS];
  logic signed [CW-1:0] acc_q [NCS][4];

  // four coefficient polynomials in q, one horner step per stage
  for (genvar s = 0; s < NCS; s++) begin : g_cst
    logic signed [IW-1:0] q_in, u_in;
    ksel_t                k_in;
    if (s == 0) begin : g_head
      assign q_in = q_i;
      assign u_in = u_i;
      assign k_in = k_i;
    end else begin : g_body
      assign q_in = cq_q[s-1];
      assign u_in = cu_q[s-1];
      assign k_in = ck_q[s-1];
    end
    for (genvar j = 0; j < 4; j++) begin : g_lane
      logic signed [CW-1:0] a_in, a_mul;
      if (s == 0) begin : g_init
        assign a_in = cval(k_in, j, 6);
      end else begin : g_prev
        assign a_in = acc_q[s-1][j];
      end
      bkw_rmul #(.AW(CW), .BW(IW), .RW(CW), .FRAC_BITS(FRAC_BITS)) u_mul (
        .a_i(a_in), .b_i(q_in), .p_o(a_mul)
      );
      always_ff @(posedge clk_i) begin
        if (en_i) acc_q[s][j] <= a_mul + cval(k_in, j, 5 - s);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cq_q[s] <= q_in;
        cu_q[s] <= u_in;
        ck_q[s] <= k_in;
      end
    end
  end

  // shape factor, runs beside the first two q stages
  logic signed [IW-1:0] opu_c, qmu_c, opu_q, qmu_q;
  logic signed [SW-1:0] sq_c, sq_q, cub_c, s_c;
  logic signed [SW-1:0] sh_q [1:8];

  assign opu_c = I_ONE + u_i;
  assign qmu_c = q_i - u_i;

  bkw_rmul #(.AW(IW), .BW(IW), .RW(SW), .FRAC_BITS(FRAC_BITS)) u_sq (
    .a_i(opu_c), .b_i(opu_c), .p_o(sq_c)
  );
  bkw_rmul #(.AW(SW), .BW(IW), .RW(SW), .FRAC_BITS(FRAC_BITS)) u_cub (
    .a_i(sq_q), .b_i(qmu_q), .p_o(cub_c)
  );

  always_comb begin
    case (KSHAPE[kidx(ck_q[0])])
      SHAPE_ONE: s_c = S_ONE;
      SHAPE_LIN: s_c = SW'(opu_q);
      default:   s_c = cub_c;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_c;
      opu_q <= opu_c;
      qmu_q <= qmu_c;
      sh_q[1] <= s_c;
      for (int i = 2; i <= 8; i++) sh_q[i] <= sh_q[i-1];
    end
  end

  // horner in u over the four coefficients
  logic signed [PW-1:0] p6_c, p7_c, p8_c, p6_q, p7_q, p8_q;
  logic signed [CW-1:0] c1_q, c0_6_q, c0_7_q;
  logic signed [IW-1:0] u6_q, u7_q;
  logic signed [PSW-1:0] ps_c, ps_q;
  logic signed [PW-1:0] c3_ext, m6_c, m7_c, m8_c;

  assign c3_ext = PW'(acc_q[NCS-1][3]);

  bkw_rmul #(.AW(PW), .BW(IW), .RW(PW), .FRAC_BITS(FRAC_BITS)) u_p6 (
    .a_i(c3_ext), .b_i(cu_q[NCS-1]), .p_o(m6_c)
  );
  bkw_rmul #(.AW(PW), .BW(IW), .RW(PW), .FRAC_BITS(FRAC_BITS)) u_p7 (
    .a_i(p6_q), .b_i(u6_q), .p_o(m7_c)
  );
  bkw_rmul #(.AW(PW), .BW(IW), .RW(PW), .FRAC_BITS(FRAC_BITS)) u_p8 (
    .a_i(p7_q), .b_i(u7_q), .p_o(m8_c)
  );
  bkw_rmul #(.AW(PW), .BW(SW), .RW(PSW), .FRAC_BITS(FRAC_BITS)) u_ps (
    .a_i(p8_q), .b_i(sh_q[8]), .p_o(ps_c)
  );

  assign p6_c = m6_c + PW'(acc_q[NCS-1][2]);
  assign p7_c = m7_c + PW'(c1_q);
  assign p8_c = m8_c + PW'(c0_7_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p6_q   <= p6_c;
      c1_q   <= acc_q[NCS-1][1];
      c0_6_q <= acc_q[NCS-1][0];
      u6_q   <= cu_q[NCS-1];
      p7_q   <= p7_c;
      c0_7_q <= c0_6_q;
      u7_q   <= u6_q;
      p8_q   <= p8_c;
      ps_q   <= ps_c;
    end
  end

  assign ps_o = ps_q;

endmodule

// ===== rtl/bkw_norm.sv =====
module bkw_norm #(
  parameter int FRAC_BITS = bkw_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [FRAC_BITS+bkw_pkg::IW_X-1:0] q_i,
  input  bkw_pkg::ksel_t                            k_i,
  output logic [FRAC_BITS+bkw_pkg::NW_X-1:0]        n_o
);
  import bkw_pkg::*;

  localparam int IW  = FRAC_BITS + IW_X;
  localparam int DW  = FRAC_BITS + 18;
  localparam int DUW = DW - 1;
  localparam int NW  = FRAC_BITS + NW_X;
  localparam int NMW = 2 * FRAC_BITS + 14;

  localparam logic signed [IW-1:0] I_ONE = IW'(2**FRAC_BITS);
  localparam logic signed [DW-1:0] D_ONE = DW'(2**FRAC_BITS);

  logic signed [DW-1:0] d_q   [POW_MAX];
  logic signed [IW-1:0] opq_q [POW_MAX];
  ksel_t                dk_q  [POW_MAX];

  // (1+q)^n, one rounded product per stage, later stages pass through
  for (genvar t = 0; t < POW_MAX; t++) begin : g_pow
    logic signed [DW-1:0] d_in, d_mul;
    logic signed [IW-1:0] opq_in;
    ksel_t                k_in;
    if (t == 0) begin : g_head
      assign d_in   = D_ONE;
      assign opq_in = I_ONE + q_i;
      assign k_in   = k_i;
    end else begin : g_body
      assign d_in   = d_q[t-1];
      assign opq_in = opq_q[t-1];
      assign k_in   = dk_q[t-1];
    end
    bkw_rmul #(.AW(DW), .BW(IW), .RW(DW), .FRAC_BITS(FRAC_BITS)) u_mul (
      .a_i(d_in), .b_i(opq_in), .p_o(d_mul)
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[t]   <= (4'(t) < KPOW[kidx(k_in)]) ? d_mul : d_in;
        opq_q[t] <= opq_in;
        dk_q[t]  <= k_in;
      end
    end
  end

  // restoring divider, one quotient bit per stage, rounding via +d/2
  logic [NMW-1:0] r_q   [NW];
  logic [DUW-1:0] den_q [NW];
  logic [NW-1:0]  quo_q [NW];

  for (genvar b = 0; b < NW; b++) begin : g_div
    localparam int SH = NW - 1 - b;
    logic [NMW-1:0] r_in;
    logic [DUW-1:0] den_in;
    logic [NW-1:0]  quo_in;
    logic           ge;
    if (b == 0) begin : g_head
      assign den_in = d_q[POW_MAX-1][DUW-1:0];
      assign r_in   = (NMW'(KNUM[kidx(dk_q[POW_MAX-1])]) << (2 * FRAC_BITS))
                    + NMW'(den_in >> 1);
      assign quo_in = '0;
    end else begin : g_body
      assign den_in = den_q[b-1];
      assign r_in   = r_q[b-1];
      assign quo_in = quo_q[b-1];
    end
    assign ge = (r_in >> SH) >= NMW'(den_in);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[b]   <= ge ? r_in - (NMW'(den_in) << SH) : r_in;
        den_q[b] <= den_in;
        quo_q[b] <= quo_in | (ge ? (NW'(1) << SH) : '0);
      end
    end
  end

  assign n_o = quo_q[NW-1];

endmodule

// ===== rtl/boundary_kernel_weight_eval.sv =====
// channel  direction  handshake                payload
// cfg      in         cfg_valid_i/cfg_ready_o  kernel_select_i
// in       in         in_valid_i/in_ready_o    sample_pos_i, boundary_ratio_i
// out      out        out_valid_o/out_ready_i  weight_o, saturated_o
//
// one transaction per cycle while the output queue has room; the path to the output queue
// runs through the (1+q)^n chain (10 stages), the one-bit-per-stage divider and the final product.
// rst_ni clears valid bits, the queue and kernel_select (to kernel 0).
// the pipe advances as one while the 2-entry output queue has room, so a
// waiting result does not block input until a second result is queued.
module boundary_kernel_weight_eval #(
  parameter int FRAC_BITS = bkw_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  bkw_pkg::ksel_t                         kernel_select_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [bkw_pkg::POS_W-1:0]       sample_pos_i,
  input  logic [bkw_pkg::RATIO_W-1:0]            boundary_ratio_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [bkw_pkg::WEIGHT_W-1:0]    weight_o,
  output logic                                   saturated_o
);
  import bkw_pkg::*;

  localparam int IW     = FRAC_BITS + IW_X;
  localparam int NW     = FRAC_BITS + NW_X;
  localparam int PSW    = FRAC_BITS + PSW_X;
  localparam int ML     = PSW / 2;
  localparam int MH     = PSW - ML;
  localparam int VPW    = NW + PSW;
  localparam int VMW    = VPW - FRAC_BITS;
  localparam int CVW    = (FRAC_BITS > 16) ? VMW : 49 - FRAC_BITS;
  localparam int PS_DLY = POW_MAX + NW - POLY_LAT;
  localparam int TOT    = POW_MAX + NW + 3;

  // kernel select register
  ksel_t ksel_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q <= '0;
    end else if (cfg_valid_i) begin
      ksel_q <= kernel_select_i;
    end
  end

  logic adv;
  logic [1:0] cnt_q;
  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  // input conversion to FRAC_BITS
  logic signed [IW-1:0] u_c, q_c, u_q, q_q;
  ksel_t                k_q;

  if (FRAC_BITS >= 16) begin : g_cv_in_shift
    assign u_c = IW'(sample_pos_i) <<< (FRAC_BITS - 16);
    assign q_c = IW'(boundary_ratio_i) << (FRAC_BITS - 16);
  end else begin : g_cv_in_round
    localparam int SH = 16 - FRAC_BITS;
    logic [POS_W-1:0] pos_mag;
    logic [POS_W:0]   pos_rnd;
    logic [RATIO_W:0] rat_rnd;
    assign pos_mag = sample_pos_i[POS_W-1] ? POS_W'(~sample_pos_i + 1'b1)
                                           : POS_W'(sample_pos_i);
    assign pos_rnd = ((POS_W+1)'(pos_mag) + (POS_W+1)'(2**(SH-1))) >> SH;
    assign rat_rnd = ((RATIO_W+1)'(boundary_ratio_i) + (RATIO_W+1)'(2**(SH-1))) >> SH;
    assign u_c = sample_pos_i[POS_W-1] ? -IW'(pos_rnd) : IW'(pos_rnd);
    assign q_c = IW'(rat_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q <= u_c;
      q_q <= q_c;
      k_q <= ksel_q;
    end
  end

  logic [TOT-1:0] vld_q, bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) bad_q <= {bad_q[TOT-2:0], ksel_q > KER_LAST};
  end

  // polynomial and normalizer run side by side
  logic signed [PSW-1:0] ps;
  logic [NW-1:0]         n_al;

  bkw_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk_i(clk_i), .en_i(adv), .u_i(u_q), .q_i(q_q), .k_i(k_q), .ps_o(ps)
  );

  bkw_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk_i(clk_i), .en_i(adv), .q_i(q_q), .k_i(k_q), .n_o(n_al)
  );

  logic signed [PSW-1:0] ps_dly_q [PS_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ps_dly_q[0] <= ps;
      for (int i = 1; i < PS_DLY; i++) ps_dly_q[i] <= ps_dly_q[i-1];
    end
  end

  // final product as two partial products, then sum and round
  logic signed [PSW-1:0] ps_al;
  logic [PSW-1:0]        ps_mag;
  logic [NW+ML-1:0]      pl_q;
  logic [NW+MH-1:0]      ph_q;
  logic                  neg1_q, neg2_q;
  logic [VPW-1:0]        prod;
  logic [VMW-1:0]        vm_q;

  assign ps_al  = ps_dly_q[PS_DLY-1];
  assign ps_mag = ps_al[PSW-1] ? PSW'(~ps_al + 1'b1) : PSW'(ps_al);
  assign prod   = (VPW'(ph_q) << ML) + VPW'(pl_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl_q   <= (NW+ML)'(n_al) * (NW+ML)'(ps_mag[ML-1:0]);
      ph_q   <= (NW+MH)'(n_al) * (NW+MH)'(ps_mag[PSW-1:ML]);
      neg1_q <= ps_al[PSW-1];
      vm_q   <= VMW'((prod + VPW'(2**(FRAC_BITS-1))) >> FRAC_BITS);
      neg2_q <= neg1_q;
    end
  end

  // conversion to Q15.16 with clipping
  logic [CVW-1:0]      mr, lim, mclip;
  logic                sat_c;
  logic [WEIGHT_W-1:0] w_c;

  if (FRAC_BITS > 16) begin : g_cv_out_round
    assign mr = CVW'((vm_q + VMW'(2**(FRAC_BITS-17))) >> (FRAC_BITS - 16));
  end else begin : g_cv_out_shift
    localparam logic [VMW-1:0] CAP = VMW'(64'h1_0000_0000);
    assign mr = (vm_q > CAP) ? (CVW'(CAP) << (16 - FRAC_BITS))
                             : (CVW'(vm_q) << (16 - FRAC_BITS));
  end

  assign lim   = neg2_q ? CVW'(32'h8000_0000) : CVW'(32'h7fff_ffff);
  assign sat_c = (mr > lim) && !bad_q[TOT-1];
  assign mclip = (mr > lim) ? lim : mr;
  assign w_c   = bad_q[TOT-1] ? '0
               : (neg2_q ? -mclip[WEIGHT_W-1:0] : mclip[WEIGHT_W-1:0]);

  // two-entry output queue
  logic                       push, pop, wp_q, rp_q;
  logic signed [WEIGHT_W-1:0] ow_q [2];
  logic                       os_q [2];

  assign push = adv && vld_q[TOT-1];
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ow_q[wp_q] <= w_c;
      os_q[wp_q] <= sat_c;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign weight_o    = ow_q[rp_q];
  assign saturated_o = os_q[rp_q];

`ifndef NO_ASSERTIONS
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[TOT-1] && !adv |=> vld_q[TOT-1])
    else $error("last stage lost its transaction during a stall");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (weight_o == 32'sh7fff_ffff || weight_o == 32'sh8000_0000))
    else $error("saturated weight not at a range limit");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("output queue count did not follow a push");
`endif

endmodule
